### rtl/stx_xor_frame_receiver_unit_defines.svh
// ----------------------------------------------------------------------------
// stx frame receiver assertion macros
// shared concurrent assertion helpers, clocked on posedge, reset disables
// ----------------------------------------------------------------------------
`ifndef STX_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define STX_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication
`define STXFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STXFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stxfr_pkg.sv
// ----------------------------------------------------------------------------
// stxfr_pkg
// constants and controller/datapath interface types of the stx frame receiver
// ----------------------------------------------------------------------------
package stxfr_pkg;

    localparam int DEF_FRAME_BUFFER_DEPTH = 64;
    localparam int DEF_PAYLOAD_LIMIT      = 32;

    localparam logic [7:0] START_BYTE     = 8'h02;
    localparam int         FRAME_OVERHEAD = 5;
    localparam int         PAYLOAD_OFFSET = 4;

    // header positions inside the frame
    localparam int POS_TYPE   = 1;
    localparam int POS_ID     = 2;
    localparam int POS_LENGTH = 3;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 6;
    localparam int INDEX_W  = 5;
    // internal payload counter, wide enough for the largest payload limit
    localparam int COUNT_W  = 6;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic take_byte;    // rx request accepted
        logic start_emit;   // accepted byte closes a good frame
        logic next_result;  // msg request accepted
    } stxfr_cmd_t;

    typedef struct packed {
        logic frame_good;   // current rx byte completes a frame that passes
        logic last_result;  // result on the msg port is the final one
    } stxfr_status_t;

endpackage

### rtl/stxfr_ctrl.sv
// ----------------------------------------------------------------------------
// stxfr_ctrl
// receive/emit sequencer: owns both handshakes and issues datapath commands
// ----------------------------------------------------------------------------
module stxfr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rx_valid,
    output logic                    rx_stall,
    output logic                    msg_valid,
    input  logic                    msg_stall,
    input  stxfr_pkg::stxfr_status_t status,
    output stxfr_pkg::stxfr_cmd_t    cmd
);
    import stxfr_pkg::*;

    localparam logic ST_RECV = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    assign rx_stall  = (state_reg != ST_RECV);
    assign msg_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd.take_byte   = rx_valid && !rx_stall;
        cmd.start_emit  = cmd.take_byte && status.frame_good;
        cmd.next_result = msg_valid && !msg_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (cmd.start_emit)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.next_result && status.last_result)
                    state_next = ST_RECV;
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RECV;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/stxfr_dpath.sv
// ----------------------------------------------------------------------------
// stxfr_dpath
// frame buffer, fill position, running checksum, header capture, result regs
// ----------------------------------------------------------------------------
module stxfr_dpath #(
    parameter int FRAME_BUFFER_DEPTH = stxfr_pkg::DEF_FRAME_BUFFER_DEPTH,
    parameter int PAYLOAD_LIMIT      = stxfr_pkg::DEF_PAYLOAD_LIMIT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [stxfr_pkg::BYTE_W-1:0]         rx_byte,
    input  stxfr_pkg::stxfr_cmd_t                cmd,
    output stxfr_pkg::stxfr_status_t             status,
    output logic [stxfr_pkg::BYTE_W-1:0]         msg_type,
    output logic [stxfr_pkg::BYTE_W-1:0]         msg_id,
    output logic [stxfr_pkg::LENGTH_W-1:0]       payload_length,
    output logic [stxfr_pkg::INDEX_W-1:0]        byte_index,
    output logic [stxfr_pkg::BYTE_W-1:0]         payload_byte,
    output logic                                 has_data,
    output logic                                 last
);
    import stxfr_pkg::*;

    localparam int AW = $clog2(FRAME_BUFFER_DEPTH);
    localparam int PW = $clog2(FRAME_BUFFER_DEPTH + 1);

    byte_t mem [FRAME_BUFFER_DEPTH];

    logic [PW-1:0] pos_reg, pos_next, pos_inc;
    byte_t         xor_reg, xor_next;
    byte_t         type_reg, id_reg, len_reg;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    byte_t         rdata_reg;

    logic          active;
    logic          buffer_full;
    logic          frame_end;
    logic          rd_en;
    logic [7:0]    rd_full;
    logic [AW-1:0] rd_addr;
    logic          empty;

    assign active      = (pos_reg != '0) || (rx_byte == START_BYTE);
    assign pos_inc     = pos_reg + 1'b1;
    assign buffer_full = (pos_inc == PW'(FRAME_BUFFER_DEPTH));
    // length byte is only meaningful once it has been stored, and the
    // compare cannot match before that since length+5 is at least five
    assign frame_end   = ({1'b0, 8'(pos_inc)} == ({1'b0, len_reg} + 9'(FRAME_OVERHEAD)));

    assign status.frame_good = active && !buffer_full && frame_end
                               && ({1'b0, len_reg} <= 9'(PAYLOAD_LIMIT))
                               && (xor_reg == rx_byte);

    always_comb
    begin
        pos_next = pos_reg;
        xor_next = xor_reg;
        if (cmd.take_byte && active)
        begin
            if (buffer_full || frame_end)
                pos_next = '0;
            else
                pos_next = pos_inc;
            // running xor over everything after the start byte
            if (pos_reg == '0)
                xor_next = '0;
            else
                xor_next = xor_reg ^ rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            xor_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    // header capture
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            if (pos_reg == PW'(POS_TYPE))
                type_reg <= rx_byte;
            if (pos_reg == PW'(POS_ID))
                id_reg <= rx_byte;
            if (pos_reg == PW'(POS_LENGTH))
                len_reg <= rx_byte;
        end
    end

    // result index
    always_comb
    begin
        priority if (cmd.start_emit)
            idx_next = '0;
        else if (cmd.next_result)
            idx_next = idx_reg + 1'b1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign empty              = (len_reg == '0);
    assign status.last_result = empty || ({2'b00, idx_reg} + 8'd1 == len_reg);

    // fetch payload byte 0 on start_emit, then the next on each non-last take
    assign rd_en   = cmd.start_emit || (cmd.next_result && !status.last_result);
    assign rd_full = 8'(PAYLOAD_OFFSET) + {2'b00, idx_next};
    assign rd_addr = rd_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && active)
            mem[pos_reg[AW-1:0]] <= rx_byte;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign msg_type       = type_reg;
    assign msg_id         = id_reg;
    assign payload_length = len_reg[LENGTH_W-1:0];
    assign byte_index     = idx_reg[INDEX_W-1:0];
    assign payload_byte   = empty ? '0 : rdata_reg;
    assign has_data       = !empty;
    assign last           = status.last_result;

endmodule

### rtl/stx_xor_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// stx_xor_frame_receiver_unit
// start-byte framed receiver with xor checksum and per-byte payload output
// ----------------------------------------------------------------------------
// Bytes are taken on the rx port one per cycle while the block is receiving.
// Bytes are dropped until a 0x02 start byte, then stored as start, type, id,
// length, payload, checksum; a frame that fills the buffer, has a length above
// PAYLOAD_LIMIT or fails the xor check is dropped without a result. The byte
// that closes a good frame is followed by max(length,1) results, one
// msg request per cycle when msg_stall is low, read from the frame buffer's
// registered read port; rx_stall stays high during that burst until the last
// result is taken, and msg stalls lengthen it. The checksum is accumulated as
// bytes arrive and the frame buffer needs no clearing after reset.
module stx_xor_frame_receiver_unit #(
    parameter int FRAME_BUFFER_DEPTH = stxfr_pkg::DEF_FRAME_BUFFER_DEPTH,
    parameter int PAYLOAD_LIMIT      = stxfr_pkg::DEF_PAYLOAD_LIMIT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rx_valid,
    output logic                           rx_stall,
    input  logic [stxfr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                           msg_valid,
    input  logic                           msg_stall,
    output logic [stxfr_pkg::BYTE_W-1:0]   msg_type,
    output logic [stxfr_pkg::BYTE_W-1:0]   msg_id,
    output logic [stxfr_pkg::LENGTH_W-1:0] payload_length,
    output logic [stxfr_pkg::INDEX_W-1:0]  byte_index,
    output logic [stxfr_pkg::BYTE_W-1:0]   payload_byte,
    output logic                           has_data,
    output logic                           last
);
    import stxfr_pkg::*;

    `include "stx_xor_frame_receiver_unit_defines.svh"

    stxfr_cmd_t    cmd;
    stxfr_status_t status;

    stxfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .status    (status),
        .cmd       (cmd)
    );

    stxfr_dpath #(
        .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH),
        .PAYLOAD_LIMIT      (PAYLOAD_LIMIT)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .msg_type       (msg_type),
        .msg_id         (msg_id),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_data       (has_data),
        .last           (last)
    );

    `STXFR_ASSERT_NEXT(a_good_frame_emits, clk, rst_n,
        cmd.start_emit, msg_valid && (byte_index == '0), "good frame did not start emission")
    `STXFR_ASSERT_NEXT(a_last_frees_rx, clk, rst_n,
        msg_valid && !msg_stall && last, !rx_stall, "rx still stalled after last result")
    `STXFR_ASSERT_NEXT(a_index_steps, clk, rst_n,
        msg_valid && !msg_stall && !last,
        msg_valid && (byte_index == INDEX_W'($past(byte_index) + 1'b1)),
        "payload index did not advance by one")
    `STXFR_ASSERT_SAME(a_empty_is_last, clk, rst_n,
        msg_valid && !has_data, last && (payload_byte == '0),
        "empty frame result malformed")

endmodule
